// File: rtl/text_console_writer_defines.svh
// Assertion helpers used by the console top level.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define TCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned TERM_W     = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COLARG_W   = 7;
  localparam int unsigned ROWARG_W   = 5;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned ATTR_W     = 8;
  localparam int unsigned CELL_W     = CHAR_W + ATTR_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h03;

  typedef enum logic [OP_W-1:0] {
    OP_PUT        = 3'd0,
    OP_BACKSPACE  = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_SET_CURSOR = 3'd3,
    OP_READ       = 3'd4
  } tcw_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_ATTR    = 1'b0,
    CFG_DISPLAY_TERM = 1'b1
  } tcw_cfg_e;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [TERM_W-1:0]   terminal_index;
    logic [CHAR_W-1:0]   char_code;
    logic [COLARG_W-1:0] column_arg;
    logic [ROWARG_W-1:0] row_arg;
  } tcw_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              did_scroll;
  } tcw_rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scroll_step;
    logic fill_step;
    logic resp;
  } tcw_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic need_fill;
    logic scroll_last;
    logic fill_last;
  } tcw_status_t;

endpackage

`default_nettype wire

// File: rtl/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 6000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire tcw_pkg::tcw_status_t status_i,
  output tcw_pkg::tcw_cmd_t         cmd_o,
  output logic                      busy_o,
  output logic                      done_o
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.need_scroll) begin
          state_d = S_SCROLL;
        end else if (status_i.need_fill) begin
          state_d = S_FILL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (status_i.scroll_last) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.resp = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_d = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/tcw_datapath.sv
`default_nettype none

module tcw_datapath #(
  parameter int unsigned TERMINALS = 3,
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tcw_pkg::tcw_cmd_t                   cmd_i,
  output tcw_pkg::tcw_status_t                     status_o,
  input  wire tcw_pkg::tcw_req_t                   req_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output tcw_pkg::tcw_rsp_t                        rsp_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned TOTAL = TERMINALS * CELLS;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned TIW   = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  function automatic logic [AW-1:0] cell_addr(logic [TIW-1:0] t, logic [RW-1:0] r,
                                              logic [CW-1:0] c);
    return AW'((32'(t) * ROWS + 32'(r)) * COLUMNS + 32'(c));
  endfunction

  tcw_pkg::tcw_req_t             req_q;
  logic [tcw_pkg::ATTR_W-1:0]    attr_q;
  logic [tcw_pkg::TERM_W-1:0]    dt_q;
  logic [CW-1:0]                 col_q [TERMINALS];
  logic [CW-1:0]                 col_d [TERMINALS];
  logic [RW-1:0]                 row_q [TERMINALS];
  logic [RW-1:0]                 row_d [TERMINALS];
  logic [AW-1:0]                 ptr_q, ptr_d, lim_q, lim_d, wr_q;
  logic                          wv_q, wv_d, zero_q, zero_d, scr_q, scr_d;
  tcw_pkg::tcw_rsp_t             rsp_q, rsp_d;

  logic                          t_ok, dt_ok, newline, at_last_col, at_last_row;
  logic                          is_put, is_bs, is_clr, is_set, is_rd, row_inc, wrap;
  logic [TIW-1:0]                ti, di, sel;
  logic [CW-1:0]                 cur_c, col_s, bs_c;
  logic [RW-1:0]                 cur_r, row_s, bs_r;
  logic [AW-1:0]                 base;
  logic [tcw_pkg::CELL_W-1:0]    blank, rdata, wdata;
  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr;

  assign t_ok  = 32'(req_q.terminal_index) < TERMINALS;
  assign dt_ok = 32'(dt_q) < TERMINALS;
  assign ti    = TIW'(req_q.terminal_index);
  assign di    = TIW'(dt_q);
  assign sel   = cmd_i.resp ? di : ti;
  assign cur_c = col_q[sel];
  assign cur_r = row_q[sel];

  assign col_s = (32'(req_q.column_arg) > COLUMNS - 1) ? CW'(COLUMNS - 1)
                                                       : CW'(req_q.column_arg);
  assign row_s = (32'(req_q.row_arg) > ROWS - 1) ? RW'(ROWS - 1) : RW'(req_q.row_arg);

  assign newline     = (req_q.char_code == tcw_pkg::CHAR_LF) ||
                       (req_q.char_code == tcw_pkg::CHAR_CR);
  assign at_last_col = (cur_c == CW'(COLUMNS - 1));
  assign at_last_row = (cur_r == RW'(ROWS - 1));

  assign is_put  = (req_q.operation == tcw_pkg::OP_PUT) && t_ok;
  assign is_bs   = (req_q.operation == tcw_pkg::OP_BACKSPACE) && t_ok &&
                   !((cur_c == '0) && (cur_r == '0));
  assign is_clr  = (req_q.operation == tcw_pkg::OP_CLEAR) && t_ok;
  assign is_set  = (req_q.operation == tcw_pkg::OP_SET_CURSOR) && dt_ok;
  assign is_rd   = (req_q.operation == tcw_pkg::OP_READ) && t_ok;
  assign row_inc = is_put && (newline || at_last_col);
  assign wrap    = row_inc && at_last_row;

  assign bs_c  = (cur_c == '0) ? CW'(COLUMNS - 1) : cur_c - CW'(1);
  assign bs_r  = (cur_c == '0) ? cur_r - RW'(1) : cur_r;
  assign base  = cell_addr(ti, '0, '0);
  assign blank = {attr_q, tcw_pkg::CHAR_SPACE};

  assign status_o.need_scroll = wrap;
  assign status_o.need_fill   = is_clr;
  assign status_o.scroll_last = ((ptr_q + AW'(COLUMNS - 1)) == lim_q);
  assign status_o.fill_last   = (ptr_q == lim_q);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    ptr_d  = ptr_q;
    lim_d  = lim_q;
    zero_d = zero_q;
    scr_d  = scr_q;
    wv_d   = cmd_i.scroll_step && !status_o.scroll_last;
    if (cmd_i.exec) begin
      scr_d = wrap;
      if (is_put) begin
        if (wrap) begin
          col_d[ti] = '0;
          row_d[ti] = RW'(ROWS - 1);
        end else if (row_inc) begin
          col_d[ti] = '0;
          row_d[ti] = cur_r + RW'(1);
        end else begin
          col_d[ti] = cur_c + CW'(1);
        end
      end
      if (is_bs) begin
        col_d[ti] = bs_c;
        row_d[ti] = bs_r;
      end
      if (is_clr) begin
        col_d[ti] = '0;
        row_d[ti] = '0;
      end
      if (is_set) begin
        col_d[di] = col_s;
        row_d[di] = row_s;
      end
      if (is_clr || wrap) begin
        ptr_d  = base;
        lim_d  = base + AW'(CELLS - 1);
        zero_d = 1'b0;
      end
    end
    if (cmd_i.scroll_step && !status_o.scroll_last) begin
      ptr_d = ptr_q + AW'(1);
    end
    if (cmd_i.fill_step && !status_o.fill_last) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = blank;
    if (wv_q) begin
      we    = 1'b1;
      waddr = wr_q;
      wdata = rdata;
    end else if (cmd_i.fill_step) begin
      we    = 1'b1;
      wdata = zero_q ? '0 : blank;
    end else if (cmd_i.exec && is_put && !newline) begin
      we    = 1'b1;
      waddr = cell_addr(ti, cur_r, cur_c);
      wdata = {attr_q, req_q.char_code};
    end else if (cmd_i.exec && is_bs) begin
      we    = 1'b1;
      waddr = cell_addr(ti, bs_r, bs_c);
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = ptr_q + AW'(COLUMNS);
    if (cmd_i.scroll_step && !status_o.scroll_last) begin
      re = 1'b1;
    end else if (cmd_i.exec && is_rd) begin
      re    = 1'b1;
      raddr = cell_addr(ti, row_s, col_s);
    end
  end

  always_comb begin
    rsp_d.cursor_position = dt_ok ? tcw_pkg::POS_W'(32'(cur_r) * COLUMNS + 32'(cur_c)) : '0;
    rsp_d.cell_char       = is_rd ? rdata[tcw_pkg::CHAR_W-1:0] : '0;
    rsp_d.cell_attr       = is_rd ? rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
    rsp_d.did_scroll      = scr_q;
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
      dt_q   <= '0;
      for (int i = 0; i < TERMINALS; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
      ptr_q  <= '0;
      lim_q  <= AW'(TOTAL - 1);
      zero_q <= 1'b1;
      wv_q   <= 1'b0;
      scr_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tcw_pkg::CFG_TEXT_ATTR:    attr_q <= cfg_wdata_i;
          tcw_pkg::CFG_DISPLAY_TERM: dt_q   <= cfg_wdata_i[tcw_pkg::TERM_W-1:0];
          default: begin
          end
        endcase
      end
      col_q  <= col_d;
      row_q  <= row_d;
      ptr_q  <= ptr_d;
      lim_q  <= lim_d;
      zero_q <= zero_d;
      wv_q   <= wv_d;
      scr_q  <= scr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scroll_step) begin
      wr_q <= ptr_q;
    end
    if (cmd_i.resp) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// Flow: a request is captured on leaving IDLE and executed in EXEC; its result and the
//   result strobe are registered in DONE. A clear adds a fill of the terminal, a scroll
//   a row copy and a fill of the last row, both bound by the one write port of the cell
//   memory. A new request is taken as the strobe shows. The receiver cannot stall.
// Reset: cursors home, attribute 0x03, display terminal 0; then busy stays high while the
//   cell memory (TERMINALS*ROWS*COLUMNS cells, 6000 by default) is zeroed.
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int unsigned TERMINALS = 3,
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire tcw_pkg::tcw_req_t              req_i,
  output logic                                done_o,
  output tcw_pkg::tcw_rsp_t                   rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  tcw_datapath #(
    .TERMINALS (TERMINALS),
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

  `TCW_ASSERT_IMPLY(a_done_when_idle, clk_i, rst_ni, done_o, !busy_o, "result while busy")
  `TCW_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start_i && !busy_o, busy_o, "request not taken")
  `TCW_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o, "result strobe repeated")
  `TCW_ASSERT_IMPLY(a_one_command, clk_i, rst_ni, 1'b1, $onehot0(cmd), "commands overlap")

endmodule

`default_nettype wire
